// File: sv/assert_macros.svh
// assertion macros for the rtl top level, which checks itself
// each macro expects clk and rst_n in scope of the module that uses it
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on every clock edge out of reset
`define CATS_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define CATS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: sv/cats_pkg.sv
// shared types, constants and the crc helper for the ca table section parser
// no dependencies
`timescale 1ns / 1ps

package cats_pkg;

  localparam int CNT_W = 6;
  localparam int IN_W  = 8;
  localparam int OUT_W = 24;

  localparam logic [7:0]  TID_CA     = 8'h01;
  localparam logic [7:0]  TAG_CA     = 8'h09;
  localparam logic [12:0] PID_NULL   = 13'h1fff;
  localparam logic [31:0] CRC_POLY   = 32'h04c11db7;

  typedef enum logic [3:0] {
    OC_UPDATED   = 4'd0,
    OC_DUPLICATE = 4'd1,
    OC_SHORT     = 4'd2,
    OC_SYNTAX    = 4'd3,
    OC_TABLE_ID  = 4'd4,
    OC_LENGTH    = 4'd5,
    OC_CRC       = 4'd6,
    OC_NOT_CUR   = 4'd7,
    OC_TOO_LONG  = 4'd8
  } outcome_t;

  typedef struct packed {
    outcome_t         outcome;
    logic             over;
    logic [CNT_W-1:0] cnt;
  } status_t;

  typedef struct packed {
    logic        kind;
    logic [12:0] pid;
    outcome_t    outcome;
    logic        over;
    logic        last;
  } out_item_t;

  // msb-first crc32 over one byte
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'h0};
    for (int i = 0; i < 8; i++) begin
      if (c[31]) begin
        c = {c[30:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: sv/ca_table_section_parser.sv
// ca table section parser top level: front, queue and back
// depends on cats_pkg, cats_front, cats_queue, cats_back and assert_macros.svh
//
// usage
//   in_*  : one section byte per item in in_tdata, in_tlast on the final byte
//   out_* : result items; out_tuser 0 = ca pid item, 1 = status item; the
//           status item closes each section and carries out_tlast
//   bytes are taken one per cycle while in_tready is high; the front checks header,
//   crc32, duplicate and descriptor loop in the cycle the byte is accepted
//   a section's first result item is offered once its status has passed the
//   status queue, issue stage and output queue; kept pids of an accepted section
//   come first, one per cycle while out_tready stays high, then the status item
//   in_tready drops only while the pid queue (2 * MAX_PIDS entries) or the
//   two-entry status queue is full, e.g. while the receiver stalls
//   a stalled receiver holds out_* stable; the back part keeps a two-entry
//   output queue so one item per cycle flows when out_tready stays high
//   synchronous reset empties the queues and forgets the stored section
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ca_table_section_parser #(
  parameter int MAX_SECTION_BYTES = 1024,
  parameter int MAX_PIDS          = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] section_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [12:0] ca_pid, [16:13] outcome, [17] pid_overflow
  output logic        out_tuser,  // [0] item_kind
  output logic        out_tlast
);

  logic                       acc, pid_push, st_push, pid_rd, pid_skip, pid_full;
  logic                       st_pop, st_empty, st_full;
  logic [12:0]                pid_data, pid_rdata;
  logic [cats_pkg::CNT_W-1:0] skip_cnt;
  cats_pkg::status_t          st_wdata, st_head;
  cats_pkg::out_item_t        item;

  assign in_tready = !pid_full && !st_full;
  assign acc       = in_tvalid && in_tready;

  cats_front #(.MAX_SECTION_BYTES(MAX_SECTION_BYTES), .MAX_PIDS(MAX_PIDS)) u_front (
    .clk(clk), .rst_n(rst_n), .acc(acc), .byte_in(in_tdata), .last_in(in_tlast),
    .pid_push(pid_push), .pid_data(pid_data), .st_push(st_push), .st_data(st_wdata)
  );

  cats_queue #(.MAX_PIDS(MAX_PIDS)) u_queue (
    .clk(clk), .rst_n(rst_n), .pid_push(pid_push), .pid_data(pid_data),
    .pid_rd(pid_rd), .pid_skip(pid_skip), .skip_cnt(skip_cnt), .pid_rdata(pid_rdata),
    .pid_full(pid_full), .st_push(st_push), .st_wdata(st_wdata), .st_pop(st_pop),
    .st_head(st_head), .st_empty(st_empty), .st_full(st_full)
  );

  cats_back u_back (
    .clk(clk), .rst_n(rst_n), .st_head(st_head), .st_empty(st_empty), .st_pop(st_pop),
    .pid_rd(pid_rd), .pid_skip(pid_skip), .skip_cnt(skip_cnt), .pid_rdata(pid_rdata),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_item(item)
  );

  // result packing
  assign out_tdata = {6'b0, item.over, item.outcome, item.pid};
  assign out_tuser = item.kind;
  assign out_tlast = item.last;

  // checks
  `CATS_ASSERT_IMP(a_last_is_status, out_tvalid, out_tuser == out_tlast, "tlast not on status")
  `CATS_ASSERT_IMP(a_pid_not_null, out_tvalid && !out_tuser, item.pid != cats_pkg::PID_NULL, "null pid")
  `CATS_ASSERT_IMP(a_no_pid_overrun, pid_push, !pid_full, "pid queue overrun")
  `CATS_ASSERT_IMP(a_no_status_overrun, st_push, !st_full, "status queue overrun")

endmodule

// File: sv/cats_ram.sv
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module cats_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/cats_front.sv
// front part: per-byte header, crc, duplicate and descriptor checks
// depends on cats_pkg and cats_ram
`timescale 1ns / 1ps

module cats_front #(
  parameter int MAX_SECTION_BYTES = 1024,
  parameter int MAX_PIDS          = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  logic [7:0]       byte_in,
  input  logic             last_in,
  output logic             pid_push,
  output logic [12:0]      pid_data,
  output logic             st_push,
  output cats_pkg::status_t st_data
);

  localparam int PW   = $clog2(MAX_SECTION_BYTES);
  localparam int POSW = $clog2(MAX_SECTION_BYTES + 2);
  localparam int EW   = 15;
  localparam int CW   = cats_pkg::CNT_W;
  localparam logic [POSW-1:0] MSB_P  = POSW'(MAX_SECTION_BYTES);
  localparam logic [POSW-1:0] MSB1_P = POSW'(MAX_SECTION_BYTES + 1);

  logic [POSW-1:0]          pos_r, pos_nxt, slen_r, slen_nxt;
  logic                     bank_r, bank_nxt, match_r, match_nxt;
  logic [31:0]              crc_r, crc_nxt;
  logic [11:0]              len_r, len_nxt;
  logic                     tid_r, tid_nxt, syn_r, syn_nxt, cur_r, cur_nxt;
  logic [12:0]              dcur_r, dcur_nxt;
  logic                     tag_r, tag_nxt, pend_r, pend_nxt;
  logic [13:0]              ca_at_r, ca_at_nxt;
  logic [4:0]               phi_r, phi_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic                     over_r, over_nxt;
  logic [7:0]               old_byte;
  logic                     in_range;
  logic [EW-1:0]            p_e, c_e, dsz, at_e;
  logic [12:0]              pid_w;
  cats_pkg::outcome_t       oc;

  assign in_range = pos_r < MSB_P;
  assign p_e      = EW'(pos_r);
  assign c_e      = EW'(dcur_r);
  assign at_e     = EW'(ca_at_r);
  assign dsz      = EW'(len_r) - EW'(9);
  assign pid_w    = {phi_r, byte_in};

  // two banks of the last accepted and the incoming section
  cats_ram #(.W(8), .DEPTH(2 ** (PW + 1))) u_store (
    .clk  (clk),
    .we   (acc && in_range),
    .waddr({~bank_r, pos_r[PW-1:0]}),
    .wdata(byte_in),
    .raddr({bank_nxt, pos_nxt[PW-1:0]}),
    .rdata(old_byte)
  );

  // per-byte section walk and final verdict
  always_comb begin
    pos_nxt = pos_r;  slen_nxt = slen_r;  bank_nxt = bank_r;  match_nxt = match_r;
    crc_nxt = crc_r;  len_nxt = len_r;  tid_nxt = tid_r;  syn_nxt = syn_r;
    cur_nxt = cur_r;  dcur_nxt = dcur_r;  tag_nxt = tag_r;  pend_nxt = pend_r;
    ca_at_nxt = ca_at_r;  phi_nxt = phi_r;  cnt_nxt = cnt_r;  over_nxt = over_r;
    pid_push = 1'b0;
    st_push  = 1'b0;
    oc       = cats_pkg::OC_UPDATED;
    if (acc) begin
      if (in_range) begin
        if (pos_r >= slen_r || old_byte != byte_in) begin
          match_nxt = 1'b0;
        end
        if (p_e < EW'(3) || p_e < EW'(len_r) + EW'(3)) begin
          crc_nxt = cats_pkg::crc32_byte(crc_r, byte_in);
        end
        if (p_e == EW'(0)) begin
          if (byte_in == cats_pkg::TID_CA) tid_nxt = 1'b1;
        end else if (p_e == EW'(1)) begin
          if (byte_in[7:6] == 2'b10) syn_nxt = 1'b1;
          len_nxt = {byte_in[3:0], len_r[7:0]};
        end else if (p_e == EW'(2)) begin
          len_nxt = {len_r[11:8], byte_in};
        end else if (p_e == EW'(5)) begin
          if (byte_in[0]) cur_nxt = 1'b1;
        end
        if (p_e >= EW'(8) && len_r >= 12'd9) begin
          if (p_e == c_e + EW'(8) && c_e + EW'(1) < dsz) begin
            tag_nxt = (byte_in == cats_pkg::TAG_CA);
          end else if (p_e == c_e + EW'(9) && c_e + EW'(1) < dsz) begin
            if (tag_r && byte_in >= 8'd4 && c_e + EW'(5) < dsz) begin
              pend_nxt  = 1'b1;
              ca_at_nxt = 14'(c_e + EW'(12));
            end
            dcur_nxt = 13'(c_e + EW'(2) + EW'(byte_in));
          end else if (pend_r && p_e == at_e) begin
            phi_nxt = byte_in[4:0];
          end else if (pend_r && p_e == at_e + EW'(1)) begin
            pend_nxt = 1'b0;
            if (pid_w != cats_pkg::PID_NULL) begin
              if (cnt_r < CW'(MAX_PIDS)) begin
                pid_push = 1'b1;
                cnt_nxt  = cnt_r + 1'b1;
              end else begin
                over_nxt = 1'b1;
              end
            end
          end
        end
      end
      if (pos_r < MSB1_P) pos_nxt = pos_r + 1'b1;
      if (last_in) begin
        st_push = 1'b1;
        if (EW'(pos_nxt) < EW'(3)) oc = cats_pkg::OC_SHORT;
        else if (EW'(pos_nxt) > EW'(MAX_SECTION_BYTES)) oc = cats_pkg::OC_TOO_LONG;
        else if (slen_r != '0 && pos_nxt == slen_r && match_nxt) oc = cats_pkg::OC_DUPLICATE;
        else if (!syn_nxt) oc = cats_pkg::OC_SYNTAX;
        else if (!tid_nxt) oc = cats_pkg::OC_TABLE_ID;
        else if (EW'(len_nxt) + EW'(3) > EW'(pos_nxt) || len_nxt < 12'd9) oc = cats_pkg::OC_LENGTH;
        else if (crc_nxt != '0) oc = cats_pkg::OC_CRC;
        else if (!cur_nxt) oc = cats_pkg::OC_NOT_CUR;
        else oc = cats_pkg::OC_UPDATED;
        if (oc == cats_pkg::OC_UPDATED) begin
          bank_nxt = ~bank_r;
          slen_nxt = pos_nxt;
        end
      end
    end
    st_data.outcome = oc;
    st_data.over    = over_nxt;
    st_data.cnt     = cnt_nxt;
    pid_data        = pid_w;
    // per-section state back to its start after the final byte
    if (acc && last_in) begin
      pos_nxt = '0;  match_nxt = 1'b1;  crc_nxt = '1;  len_nxt = '0;
      tid_nxt = 1'b0;  syn_nxt = 1'b0;  cur_nxt = 1'b0;  dcur_nxt = '0;
      tag_nxt = 1'b0;  pend_nxt = 1'b0;  ca_at_nxt = '0;  phi_nxt = '0;
      cnt_nxt = '0;  over_nxt = 1'b0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;  slen_r <= '0;  bank_r <= 1'b0;  match_r <= 1'b1;
      crc_r <= '1;  len_r <= '0;  tid_r <= 1'b0;  syn_r <= 1'b0;  cur_r <= 1'b0;
      dcur_r <= '0;  tag_r <= 1'b0;  pend_r <= 1'b0;  ca_at_r <= '0;
      phi_r <= '0;  cnt_r <= '0;  over_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;  slen_r <= slen_nxt;  bank_r <= bank_nxt;  match_r <= match_nxt;
      crc_r <= crc_nxt;  len_r <= len_nxt;  tid_r <= tid_nxt;  syn_r <= syn_nxt;
      cur_r <= cur_nxt;  dcur_r <= dcur_nxt;  tag_r <= tag_nxt;  pend_r <= pend_nxt;
      ca_at_r <= ca_at_nxt;  phi_r <= phi_nxt;  cnt_r <= cnt_nxt;  over_r <= over_nxt;
    end
  end

endmodule

// File: sv/cats_queue.sv
// queue between front and back: pid ram fifo and a small status fifo
// depends on cats_pkg and cats_ram
`timescale 1ns / 1ps

module cats_queue #(
  parameter int MAX_PIDS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        pid_push,
  input  logic [12:0]                 pid_data,
  input  logic                        pid_rd,
  input  logic                        pid_skip,
  input  logic [cats_pkg::CNT_W-1:0]  skip_cnt,
  output logic [12:0]                 pid_rdata,
  output logic                        pid_full,
  input  logic                        st_push,
  input  cats_pkg::status_t           st_wdata,
  input  logic                        st_pop,
  output cats_pkg::status_t           st_head,
  output logic                        st_empty,
  output logic                        st_full
);

  localparam int QAW = $clog2(2 * MAX_PIDS);

  logic [QAW:0]      wr_r, wr_nxt, rd_r, rd_nxt;
  logic [1:0]        swr_r, swr_nxt, srd_r, srd_nxt;
  cats_pkg::status_t st_mem [2];

  // pid storage, read at the head pointer every cycle
  cats_ram #(.W(13), .DEPTH(2 ** QAW)) u_pids (
    .clk  (clk),
    .we   (pid_push),
    .waddr(wr_r[QAW-1:0]),
    .wdata(pid_data),
    .raddr(rd_r[QAW-1:0]),
    .rdata(pid_rdata)
  );

  assign pid_full = (wr_r - rd_r) == (QAW + 1)'(2 ** QAW);
  assign st_empty = swr_r == srd_r;
  assign st_full  = (swr_r[1] != srd_r[1]) && (swr_r[0] == srd_r[0]);
  assign st_head  = st_mem[srd_r[0]];

  // pointer updates; a skip drops the pids of a rejected section
  always_comb begin
    wr_nxt  = pid_push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = rd_r;
    if (pid_rd) rd_nxt = rd_r + 1'b1;
    else if (pid_skip) rd_nxt = rd_r + (QAW + 1)'(skip_cnt);
    swr_nxt = st_push ? swr_r + 1'b1 : swr_r;
    srd_nxt = st_pop ? srd_r + 1'b1 : srd_r;
  end

  // status entries
  always_ff @(posedge clk) begin
    if (st_push) begin
      st_mem[swr_r[0]] <= st_wdata;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;  rd_r <= '0;  swr_r <= '0;  srd_r <= '0;
    end else begin
      wr_r <= wr_nxt;  rd_r <= rd_nxt;  swr_r <= swr_nxt;  srd_r <= srd_nxt;
    end
  end

endmodule

// File: sv/cats_back.sv
// back part: turns queued status and pids into result items
// depends on cats_pkg
`timescale 1ns / 1ps

module cats_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cats_pkg::status_t          st_head,
  input  logic                       st_empty,
  output logic                       st_pop,
  output logic                       pid_rd,
  output logic                       pid_skip,
  output logic [cats_pkg::CNT_W-1:0] skip_cnt,
  input  logic [12:0]                pid_rdata,
  output logic                       out_valid,
  input  logic                       out_ready,
  output cats_pkg::out_item_t        out_item
);

  logic [cats_pkg::CNT_W-1:0] idx_r, idx_nxt;
  logic                       s1_v_r, s1_v_nxt;
  cats_pkg::out_item_t        s1_r, s1_nxt, push_item;
  cats_pkg::out_item_t        oq_r [2];
  logic [1:0]                 oc_r, oc_nxt;
  logic                       owr_r, owr_nxt, ord_r, ord_nxt;
  logic                       pop, issue, pid_mode;

  assign out_valid = oc_r != 2'd0;
  assign out_item  = oq_r[ord_r];
  assign pop       = out_valid && out_ready;
  assign pid_mode  = st_head.outcome == cats_pkg::OC_UPDATED && idx_r < st_head.cnt;
  assign issue     = !st_empty && ({1'b0, oc_r} + {2'b0, s1_v_r} < 3'd2 + {2'b0, pop});
  assign pid_rd    = issue && pid_mode;
  assign st_pop    = issue && !pid_mode;
  assign pid_skip  = st_pop && st_head.outcome != cats_pkg::OC_UPDATED;
  assign skip_cnt  = st_head.cnt;

  // issue stage: pick the next pid or the status item
  always_comb begin
    idx_nxt  = idx_r;
    s1_v_nxt = issue;
    s1_nxt   = s1_r;
    if (pid_rd) begin
      idx_nxt        = idx_r + 1'b1;
      s1_nxt.kind    = 1'b0;
      s1_nxt.pid     = '0;
      s1_nxt.outcome = cats_pkg::OC_UPDATED;
      s1_nxt.over    = st_head.over;
      s1_nxt.last    = 1'b0;
    end else if (st_pop) begin
      idx_nxt        = '0;
      s1_nxt.kind    = 1'b1;
      s1_nxt.pid     = '0;
      s1_nxt.outcome = st_head.outcome;
      s1_nxt.over    = st_head.outcome == cats_pkg::OC_UPDATED && st_head.over;
      s1_nxt.last    = 1'b1;
    end
    push_item     = s1_r;
    push_item.pid = s1_r.kind ? 13'd0 : pid_rdata;
    owr_nxt = s1_v_r ? ~owr_r : owr_r;
    ord_nxt = pop ? ~ord_r : ord_r;
    oc_nxt  = oc_r + {1'b0, s1_v_r} - {1'b0, pop};
  end

  // output queue entries
  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      oq_r[owr_r] <= push_item;
    end
    s1_r <= s1_nxt;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;  s1_v_r <= 1'b0;  oc_r <= '0;  owr_r <= 1'b0;  ord_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;  s1_v_r <= s1_v_nxt;  oc_r <= oc_nxt;
      owr_r <= owr_nxt;  ord_r <= ord_nxt;
    end
  end

endmodule

// File: verif/testbench.sv
// self-checking testbench for ca_table_section_parser: directed and random sections
// depends on cats_pkg and the parser rtl; predicts result items from its own model, typed rows set the outcome
`timescale 1ns / 1ps

module testbench;

  localparam int SEC_MAX   = 1024;
  localparam int PID_MAX   = 16;
  localparam int CYC_LIMIT = 400000;
  localparam int N_ITEMS   = 260;

  typedef struct {
    logic [7:0]         b;
    logic               last;
    logic               typed;
    cats_pkg::outcome_t oc;
  } stim_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  ca_table_section_parser uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // stimulus, expectations, bookkeeping
  stim_t               byte_queue[$];
  cats_pkg::out_item_t pending_results[$];
  int                  errors = 0;
  int                  cycles = 0;
  int                  sent = 0;
  int                  results_seen = 0;
  bit                  in_fire = 0;
  bit                  hold_done = 0;
  int                  hold_left = 0;
  int                  idle_mode;
  logic                cur_typed = 1'b0;
  cats_pkg::outcome_t  cur_oc = cats_pkg::OC_UPDATED;

  // idle phase follows the number of items sent
  assign idle_mode = (sent / 65) % 4;

  // parser model state
  logic [7:0]  sec_store[0:2*SEC_MAX-1];
  bit          bank;
  int unsigned kept_len;
  int unsigned pos;
  bit          same_as_kept;
  logic [31:0] crc;
  int unsigned sec_len;
  bit          tid_ok, syn_ok, cur_ok;
  int unsigned cursor;
  logic [12:0] pids[PID_MAX];
  int unsigned pid_n;
  bit          pid_ovf, is_ca_tag, ca_wait;
  int unsigned ca_pos;
  logic [4:0]  pid_top;

  function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] d);
    logic [31:0] r;
    r = c ^ {d, 24'h0};
    for (int k = 0; k < 8; k++) r = r[31] ? ({r[30:0], 1'b0} ^ 32'h04c11db7) : {r[30:0], 1'b0};
    return r;
  endfunction

  task automatic clear_walk();
    pos = 0; same_as_kept = 1; crc = '1; sec_len = 0;
    tid_ok = 0; syn_ok = 0; cur_ok = 0; cursor = 0;
    pid_n = 0; pid_ovf = 0; is_ca_tag = 0; ca_wait = 0; ca_pos = 0; pid_top = 0;
  endtask

  // walk one section byte through header, crc, duplicate and descriptor checks
  task automatic absorb_byte(int unsigned p, logic [7:0] b);
    int unsigned dsize, c;
    logic [12:0] pid;
    sec_store[(bank ? 0 : SEC_MAX) + p] = b;
    if (p >= kept_len || sec_store[(bank ? SEC_MAX : 0) + p] != b) same_as_kept = 0;
    if (p < 3 || p < 3 + sec_len) crc = crc_step(crc, b);
    case (p)
      0: tid_ok = (b == cats_pkg::TID_CA);
      1: begin
        syn_ok = (b[7:6] == 2'b10);
        sec_len = {b[3:0], 8'h00};
      end
      2: sec_len = sec_len | b;
      5: cur_ok = b[0];
      default: ;
    endcase
    if (p < 8 || sec_len < 9) return;
    dsize = sec_len - 9;
    c = cursor;
    if (p == c + 8 && c + 1 < dsize) begin
      is_ca_tag = (b == cats_pkg::TAG_CA);
    end else if (p == c + 9 && c + 1 < dsize) begin
      if (is_ca_tag && b >= 4 && c + 5 < dsize) begin
        ca_wait = 1;
        ca_pos = c + 12;
      end
      cursor = (c + 2 + b) & 13'h1fff;
    end else if (ca_wait && p == ca_pos) begin
      pid_top = b[4:0];
    end else if (ca_wait && p == ca_pos + 1) begin
      pid = {pid_top, b};
      ca_wait = 0;
      if (pid != cats_pkg::PID_NULL) begin
        if (pid_n < PID_MAX) begin
          pids[pid_n] = pid;
          pid_n++;
        end else begin
          pid_ovf = 1;
        end
      end
    end
  endtask

  // predict the result items caused by one accepted byte
  task automatic predict_section(stim_t s);
    int unsigned size;
    cats_pkg::outcome_t oc;
    cats_pkg::out_item_t r;
    if (pos < SEC_MAX) absorb_byte(pos, s.b);
    if (pos < SEC_MAX + 1) pos++;
    if (!s.last) return;
    size = pos;
    if (size < 3) oc = cats_pkg::OC_SHORT;
    else if (size > SEC_MAX) oc = cats_pkg::OC_TOO_LONG;
    else if (kept_len != 0 && size == kept_len && same_as_kept) oc = cats_pkg::OC_DUPLICATE;
    else if (!syn_ok) oc = cats_pkg::OC_SYNTAX;
    else if (!tid_ok) oc = cats_pkg::OC_TABLE_ID;
    else if (3 + sec_len > size || sec_len < 9) oc = cats_pkg::OC_LENGTH;
    else if (crc != 0) oc = cats_pkg::OC_CRC;
    else if (!cur_ok) oc = cats_pkg::OC_NOT_CUR;
    else oc = cats_pkg::OC_UPDATED;
    if (oc == cats_pkg::OC_UPDATED) begin
      bank = !bank;
      kept_len = size;
      for (int i = 0; i < pid_n; i++) begin
        r = '{kind: 1'b0, pid: pids[i], outcome: cats_pkg::OC_UPDATED, over: pid_ovf,
              last: 1'b0};
        pending_results = {pending_results, r};
      end
    end
    r = '{kind: 1'b1, pid: 13'h0, outcome: s.typed ? s.oc : oc,
          over: (oc == cats_pkg::OC_UPDATED) && pid_ovf, last: 1'b1};
    pending_results = {pending_results, r};
    clear_walk();
  endtask

  // build a well-formed section with random descriptors and a valid crc32
  // all_ca gives short ca descriptors with non-null pids only
  logic [7:0] last_good[$];

  task automatic make_section(ref logic [7:0] sec[$], input int n_desc, input bit cur,
                              input bit all_ca);
    logic [7:0] body[$];
    logic [31:0] c;
    int dl;
    body = {};
    for (int d = 0; d < n_desc; d++) begin
      if (all_ca || $urandom_range(0, 9) < 6) begin
        dl = all_ca ? 4 : 4 + $urandom_range(0, 3);
        body = {body, cats_pkg::TAG_CA, dl[7:0], 8'($urandom), 8'($urandom)};
        if (!all_ca && $urandom_range(0, 7) == 0) begin
          body = {body, 8'he0 | 8'h1f, 8'hff};
        end else begin
          body = {body, 8'($urandom_range(0, 30)), 8'($urandom)};
        end
        for (int k = 4; k < dl; k++) body = {body, 8'($urandom)};
      end else begin
        dl = $urandom_range(0, 5);
        body = {body, 8'($urandom), dl[7:0]};
        for (int k = 0; k < dl; k++) body = {body, 8'($urandom)};
      end
    end
    dl = 9 + body.size();
    sec = {cats_pkg::TID_CA, 8'hb0 | 8'(dl >> 8), 8'(dl), 8'($urandom), 8'($urandom),
           8'({$urandom_range(0, 127), cur}), 8'($urandom), 8'($urandom)};
    sec = {sec, body};
    c = '1;
    foreach (sec[i]) c = crc_step(c, sec[i]);
    sec = {sec, c[31:24], c[23:16], c[15:8], c[7:0]};
  endtask

  task automatic queue_section(logic [7:0] sec[$]);
    stim_t s;
    foreach (sec[i]) begin
      s = '{b: sec[i], last: (i == sec.size() - 1), typed: 1'b0, oc: cats_pkg::OC_UPDATED};
      byte_queue = {byte_queue, s};
    end
  endtask

  // directed cases with a typed status outcome
  stim_t fixed_rows[13] = '{
    '{8'h01, 1'b1, 1'b1, cats_pkg::OC_SHORT},
    '{8'h01, 1'b0, 1'b0, cats_pkg::OC_SHORT},
    '{8'h00, 1'b1, 1'b1, cats_pkg::OC_SHORT},
    '{8'h01, 1'b0, 1'b0, cats_pkg::OC_SYNTAX},
    '{8'h00, 1'b0, 1'b0, cats_pkg::OC_SYNTAX},
    '{8'h05, 1'b1, 1'b1, cats_pkg::OC_SYNTAX},
    '{8'h02, 1'b0, 1'b0, cats_pkg::OC_TABLE_ID},
    '{8'hb0, 1'b0, 1'b0, cats_pkg::OC_TABLE_ID},
    '{8'h09, 1'b1, 1'b1, cats_pkg::OC_TABLE_ID},
    '{8'h01, 1'b0, 1'b0, cats_pkg::OC_LENGTH},
    '{8'hb0, 1'b0, 1'b0, cats_pkg::OC_LENGTH},
    '{8'h09, 1'b1, 1'b1, cats_pkg::OC_LENGTH},
    '{8'hff, 1'b1, 1'b1, cats_pkg::OC_SHORT}
  };

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // sample both handshakes at the rising edge
  always @(posedge clk) begin
    cats_pkg::out_item_t e;
    in_fire = rst_n && in_tvalid && in_tready;
    if (in_fire) predict_section('{b: in_tdata, last: in_tlast, typed: cur_typed,
                                   oc: cur_oc});
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t unexpected item: kind %0b data %h", $realtime, out_tuser, out_tdata);
      end else begin
        e = pending_results.pop_front();
        if (out_tuser !== e.kind || out_tdata[12:0] !== e.pid ||
            out_tdata[16:13] !== e.outcome || out_tdata[17] !== e.over ||
            out_tlast !== e.last) begin
          errors++;
          // fields: kind / pid / outcome / overflow / last
          $display("%0t mismatch: expected %0b/%h/%0d/%0b/%0b got %0b/%h/%0d/%0b/%0b",
                   $realtime, e.kind, e.pid, e.outcome, e.over, e.last, out_tuser,
                   out_tdata[12:0], out_tdata[16:13], out_tdata[17], out_tlast);
        end
      end
    end
  end

  // sender: next byte offered at the falling edge
  always @(negedge clk) begin
    stim_t s;
    if (rst_n && (!in_tvalid || in_fire)) begin
      if (byte_queue.size() != 0 && !((idle_mode == 1 || idle_mode == 3) &&
          $urandom_range(0, 99) < (idle_mode == 1 ? 53 : 23))) begin
        s = byte_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= s.b;
        in_tlast <= s.last;
        cur_typed <= s.typed;
        cur_oc <= s.oc;
        sent++;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls per phase, and one long hold-off
  always @(negedge clk) begin
    if (!hold_done && sent > 150) begin
      hold_done <= 1;
      hold_left <= 400;
    end
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (idle_mode == 2 || idle_mode == 3) begin
      out_tready <= $urandom_range(0, 99) >= (idle_mode == 2 ? 53 : 23);
    end else begin
      out_tready <= rst_n;
    end
  end

  initial begin
    logic [7:0] sec[$];
    int n_good;
    clear_walk();
    bank = 0;
    kept_len = 0;
    foreach (sec_store[i]) sec_store[i] = 8'h00;
    foreach (fixed_rows[i]) byte_queue = {byte_queue, fixed_rows[i]};
    // accepted, duplicate, not current, bad crc, pid overflow
    make_section(sec, 2, 1, 0);
    queue_section(sec);
    queue_section(sec);
    make_section(sec, 0, 0, 0);
    queue_section(sec);
    make_section(sec, 1, 1, 0);
    sec[sec.size() - 1] ^= 8'h01;
    queue_section(sec);
    make_section(sec, PID_MAX + 1, 1, 1);
    queue_section(sec);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (byte_queue.size() != 0) @(posedge clk);

    // random part: mostly well-formed, some broken, some noise
    n_good = 0;
    while (sent < N_ITEMS) begin
      if (byte_queue.size() < 4) begin
        case ($urandom_range(0, 9))
          0: queue_section(last_good);
          1: begin
            sec = {};
            repeat ($urandom_range(1, 20)) sec = {sec, 8'($urandom)};
            queue_section(sec);
          end
          2: begin
            make_section(sec, $urandom_range(0, 4), 1, 0);
            sec[$urandom_range(0, sec.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
            queue_section(sec);
          end
          3: begin
            make_section(sec, $urandom_range(1, 4), 1'($urandom_range(0, 1)), 0);
            sec = sec[0:$urandom_range(0, sec.size() - 2)];
            queue_section(sec);
          end
          default: begin
            make_section(sec, (n_good % 9 == 8) ? 20 : $urandom_range(0, 4), 1, 0);
            last_good = sec;
            n_good++;
            queue_section(sec);
          end
        endcase
      end
      @(posedge clk);
    end
    while (byte_queue.size() != 0) @(posedge clk);
    @(posedge clk);
    while (in_tvalid || pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/cats_pkg.sv
sv/cats_ram.sv
sv/cats_front.sv
sv/cats_queue.sv
sv/cats_back.sv
sv/ca_table_section_parser.sv
verif/testbench.sv
